### src/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a)) else $error("assertion failed");
`define ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, a)
`define ASSERT_NEXT(label, a, c)
`endif
`endif

### src/ate_pkg.sv
`default_nettype none
package ate_pkg;
    localparam int Depth = 32;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    typedef enum logic [3:0] {
        REQ_INS_FIRST = 4'd0, REQ_INS_LAST = 4'd1, REQ_INS_POS = 4'd2,
        REQ_DEL_FIRST = 4'd3, REQ_DEL_LAST = 4'd4, REQ_DEL_POS = 4'd5,
        REQ_UPDATE = 4'd6, REQ_SORT = 4'd7, REQ_BSEARCH = 4'd8,
        REQ_LSEARCH = 4'd9, REQ_DUMP = 4'd10
    } req_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2,
        ST_BADPOS = 3'd3, ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_WR,
        S_SORT_RD, S_SORT_CMP, S_BS_RD, S_BS_CMP, S_LS_RD, S_LS_CMP,
        S_DUMP_RD, S_DUMP_OUT, S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  found_position;
        logic [31:0] element;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [31:0] value;
        logic [5:0]  position;
    } request_t;

    // memory port controls from sequencer to datapath
    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [31:0]      wdata;
        logic [AddrW-1:0] raddr_a;
        logic [AddrW-1:0] raddr_b;
    } mem_ctl_t;
endpackage
`default_nettype wire

### src/ate_if.sv
`default_nettype none
interface ate_req_if;
    logic valid;
    logic ready;
    logic [3:0] req_type;
    logic signed [31:0] value;
    logic [5:0] position;
    modport source (output valid, req_type, value, position, input ready);
    modport sink (input valid, req_type, value, position, output ready);
endinterface

interface ate_res_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [5:0] found_position;
    logic signed [31:0] element;
    logic last;
    modport source (output valid, status, found_position, element, last, input ready);
    modport sink (input valid, status, found_position, element, last, output ready);
endinterface
`default_nettype wire

### src/ate_store.sv
`default_nettype none
// Table storage: one write port, two registered read ports
module ate_store (
    input  wire logic            clk,
    input  wire ate_pkg::mem_ctl_t ctl,
    output logic [31:0]          rdata_a,
    output logic [31:0]          rdata_b
);
    import ate_pkg::*;
    logic [31:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata_a <= mem[ctl.raddr_a];
        rdata_b <= mem[ctl.raddr_b];
    end
endmodule
`default_nettype wire

### src/ate_seq.sv
`default_nettype none
// Sequencer: walks the table one entry per step through a shared compare
module ate_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire ate_pkg::request_t req,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output ate_pkg::result_t       res,
    output ate_pkg::mem_ctl_t      ctl,
    input  wire logic [31:0]       rdata_a,
    input  wire logic [31:0]       rdata_b,
    output logic [ate_pkg::CntW-1:0] count
);
    import ate_pkg::*;

    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    request_t req_reg, req_next;
    logic [CntW-1:0] i_reg, i_next;        // walking index
    logic [CntW-1:0] lim_reg, lim_next;    // walk end / sort pass end
    logic [CntW:0] lo_reg, lo_next, hi_reg, hi_next;   // binary search bounds
    logic swapped_reg, swapped_next;
    result_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;

    // shared compare unit
    logic signed [31:0] cmp_x, cmp_y;
    logic cmp_eq, cmp_gt;
    assign cmp_eq = (cmp_x == cmp_y);
    assign cmp_gt = (cmp_x > cmp_y);

    logic [CntW:0] mid;
    logic [CntW:0] pos_w, cnt_w;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pos_w = {1'b0, req_reg.position[CntW-1:0]} | ((req_reg.position >> CntW) != 0 ?
                   {1'b1, {CntW{1'b0}}} : '0);
    assign cnt_w = {1'b0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        i_reg <= i_next;
        lim_reg <= lim_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        swapped_reg <= swapped_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next = req_reg;
        i_next = i_reg;
        lim_next = lim_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        swapped_next = swapped_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg;
        ctl = '0;
        cmp_x = rdata_a;
        cmp_y = rdata_b;
        req_ready = 1'b0;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                // the result register is reused, so wait until it has left
                req_ready = !res_valid_reg;
                if (req_valid && req_ready)
                begin
                    req_next = req;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next = '{status: ST_OK, found_position: '0, element: '0, last: 1'b1};
                state_next = S_RESP;
                if (req_reg.req_type <= REQ_DUMP && req_reg.req_type != REQ_INS_FIRST &&
                    req_reg.req_type != REQ_INS_LAST && count_reg == '0)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    priority case (req_reg.req_type)
                        REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_POS:
                        begin
                            if (count_reg == CntW'(Depth))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (req_reg.req_type == REQ_INS_POS &&
                                     (pos_w == '0 || pos_w > cnt_w + 1'b1))
                            begin
                                res_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                // lim = target index; shift from count down to lim
                                lim_next = (req_reg.req_type == REQ_INS_FIRST) ? '0 :
                                           (req_reg.req_type == REQ_INS_LAST) ? count_reg :
                                           CntW'(pos_w - 1'b1);
                                i_next = count_reg;
                                state_next = S_SHUP_RD;
                            end
                        end
                        REQ_DEL_FIRST, REQ_DEL_POS:
                        begin
                            if (req_reg.req_type == REQ_DEL_POS &&
                                (pos_w == '0 || pos_w > cnt_w))
                            begin
                                res_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                i_next = (req_reg.req_type == REQ_DEL_FIRST) ? '0 :
                                         CntW'(pos_w - 1'b1);
                                state_next = S_SHDN_RD;
                            end
                        end
                        REQ_DEL_LAST:
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        REQ_UPDATE:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                res_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                ctl.we = 1'b1;
                                ctl.waddr = AddrW'(pos_w - 1'b1);
                                ctl.wdata = req_reg.value;
                            end
                        end
                        REQ_SORT:
                        begin
                            lim_next = count_reg - 1'b1;
                            i_next = '0;
                            swapped_next = 1'b0;
                            if (count_reg > CntW'(1))
                            begin
                                state_next = S_SORT_RD;
                            end
                        end
                        REQ_BSEARCH:
                        begin
                            lo_next = '0;
                            hi_next = cnt_w - 1'b1;
                            state_next = S_BS_RD;
                        end
                        REQ_LSEARCH:
                        begin
                            i_next = '0;
                            state_next = S_LS_RD;
                        end
                        REQ_DUMP:
                        begin
                            i_next = '0;
                            state_next = S_DUMP_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // insert: move entry i-1 to i until i reaches the target
            S_SHUP_RD:
            begin
                if (i_reg == lim_reg)
                begin
                    ctl.we = 1'b1;
                    ctl.waddr = AddrW'(lim_reg);
                    ctl.wdata = req_reg.value;
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.raddr_a = AddrW'(i_reg - 1'b1);
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR:
            begin
                ctl.we = 1'b1;
                ctl.waddr = AddrW'(i_reg);
                ctl.wdata = rdata_a;
                i_next = i_reg - 1'b1;
                state_next = S_SHUP_RD;
            end
            // delete: move entry i+1 to i until the end
            S_SHDN_RD:
            begin
                if (i_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.raddr_a = AddrW'(i_reg + 1'b1);
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR:
            begin
                ctl.we = 1'b1;
                ctl.waddr = AddrW'(i_reg);
                ctl.wdata = rdata_a;
                i_next = i_reg + 1'b1;
                state_next = S_SHDN_RD;
            end
            // bubble sort: compare pair (i, i+1), swap as two writes
            S_SORT_RD:
            begin
                if (i_reg >= lim_reg)
                begin
                    lim_next = lim_reg - 1'b1;
                    i_next = '0;
                    if (lim_reg <= CntW'(1))
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    ctl.raddr_a = AddrW'(i_reg);
                    ctl.raddr_b = AddrW'(i_reg + 1'b1);
                    swapped_next = 1'b0;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                if (cmp_gt && !swapped_reg)
                begin
                    ctl.we = 1'b1;
                    ctl.waddr = AddrW'(i_reg);
                    ctl.wdata = rdata_b;
                    swapped_next = 1'b1;
                end
                else
                begin
                    if (swapped_reg)
                    begin
                        ctl.we = 1'b1;
                        ctl.waddr = AddrW'(i_reg + 1'b1);
                        ctl.wdata = rdata_a;
                    end
                    // keep read data by re-reading: the pair (i, i+1) is read again
                    // below, so the registered data stays that pair
                    i_next = i_reg + 1'b1;
                    state_next = S_SORT_RD;
                end
                ctl.raddr_a = AddrW'(i_reg);
                ctl.raddr_b = AddrW'(i_reg + 1'b1);
                if (cmp_gt && !swapped_reg)
                begin
                    // hold the old pair for the second write
                    ctl.raddr_a = AddrW'(i_reg);
                    ctl.raddr_b = AddrW'(i_reg);
                end
            end
            S_BS_RD:
            begin
                if (lo_reg > hi_reg || hi_reg[CntW])
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.raddr_a = AddrW'(mid);
                    state_next = S_BS_CMP;
                end
            end
            S_BS_CMP:
            begin
                cmp_y = req_reg.value;
                state_next = S_BS_RD;
                if (cmp_eq)
                begin
                    res_next.found_position = 6'(mid + 1'b1);
                    state_next = S_RESP;
                end
                else if (cmp_gt)
                begin
                    hi_next = mid - 1'b1;
                end
                else
                begin
                    lo_next = mid + 1'b1;
                end
            end
            S_LS_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.raddr_a = AddrW'(i_reg);
                    state_next = S_LS_CMP;
                end
            end
            S_LS_CMP:
            begin
                cmp_y = req_reg.value;
                i_next = i_reg + 1'b1;
                state_next = S_LS_RD;
                if (cmp_eq)
                begin
                    res_next.found_position = 6'(i_reg + 1'b1);
                    state_next = S_RESP;
                end
            end
            S_DUMP_RD:
            begin
                ctl.raddr_a = AddrW'(i_reg);
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (!res_valid_reg)
                begin
                    res_next = '{status: ST_OK, found_position: '0, element: rdata_a,
                                 last: (i_reg + 1'b1 == count_reg)};
                    res_valid_next = 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == count_reg) ? S_IDLE : S_DUMP_RD;
                end
                else
                begin
                    ctl.raddr_a = AddrW'(i_reg);
                end
            end
            S_RESP:
            begin
                if (!res_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign count = count_reg;
endmodule
`default_nettype wire

### src/array_table_engine.sv
// Ordered table engine.
// Requests arrive on req (valid/ready, one word per request: req_type, value,
// position); results leave on res (valid/ready: status, found_position,
// element, last). Each request gives one result word, except a dump of a
// non-empty table, which gives one word per entry with last on the final one.
// One request is worked at a time; req is ready only while the sequencer idles
// and the result register is empty.
// A simple request passes the decode and response states before its result
// shows; req is ready again in the cycle after that word leaves. Inserts and
// deletes take a read and a write step per shifted entry; searches a read and
// a compare step per probed entry; sort a read and a compare step per
// compared pair, one more write step per swap and one step per pass; dump a
// read and an output step per entry. Work is paced by the single shared
// compare unit and the one table write port, which handle one entry step at a
// time.
// Reset clears the entry count and the sequencer; table contents are not
// cleared and are only read after being written.
// A stalled receiver holds the result register; the sequencer waits on it and
// no further work or dump word is produced until it is taken.
`include "assert_macros.svh"
`default_nettype none
module array_table_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    ate_req_if.sink   req,
    ate_res_if.source res
);
    import ate_pkg::*;

    request_t rq;
    result_t rs;
    mem_ctl_t ctl;
    logic [31:0] rdata_a, rdata_b;
    logic [CntW-1:0] count;

    assign rq = '{req_type: req.req_type, value: req.value, position: req.position};

    ate_seq u_seq (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req(rq),
        .res_valid(res.valid), .res_ready(res.ready), .res(rs),
        .ctl(ctl), .rdata_a(rdata_a), .rdata_b(rdata_b), .count(count)
    );

    ate_store u_store (
        .clk(clk), .ctl(ctl), .rdata_a(rdata_a), .rdata_b(rdata_b)
    );

    assign res.status = rs.status;
    assign res.found_position = rs.found_position;
    assign res.element = rs.element;
    assign res.last = rs.last;

    `ASSERT_IMPL(a_count_range, count <= CntW'(Depth))
    `ASSERT_NEXT(a_res_hold, res.valid && !res.ready, res.valid && $stable(res.element))
    `ASSERT_IMPL(a_not_both, !(req.ready && res.valid))
endmodule
`default_nettype wire
